### hw/rtl/omb_pkg.sv
package omb_pkg;

    // Payload widths fixed by the interface
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 8;
    localparam int COUNT_OUT_W = 5;

    // Default number of cells
    localparam int CAPACITY_DEF = 16;

    // Request operations
    typedef enum logic [1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_FIND     = 2'd2,
        FUNC_FIND_ALL = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic capture;   // latch the compare result against the incoming key
        logic occupied;  // cell holds a live entry
        logic write;     // load the incoming pair
        logic shift;     // take the pair of the next cell
        logic clear;     // drop the match flag once it has been reported
    } cell_ctrl_t;

endpackage

### hw/rtl/omb_cell.sv
module omb_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  omb_pkg::cell_ctrl_t       ctrl,
    input  logic [omb_pkg::KEY_W-1:0] in_key,
    input  logic [omb_pkg::VAL_W-1:0] in_value,
    input  logic [omb_pkg::KEY_W-1:0] next_key,
    input  logic [omb_pkg::VAL_W-1:0] next_value,
    output logic [omb_pkg::KEY_W-1:0] cell_key,
    output logic [omb_pkg::VAL_W-1:0] cell_value,
    output logic                      match
);

    logic [omb_pkg::KEY_W-1:0] key_reg;
    logic [omb_pkg::VAL_W-1:0] value_reg;
    logic                      match_reg;

    // Entry storage: load on add, take the neighbor's pair on remove
    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        else if (ctrl.shift)
        begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

    // Match flag: set by the compare at request time, cleared once a find-all reports it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= ctrl.occupied && (in_key == key_reg);
        end
        else if (ctrl.clear)
        begin
            match_reg <= 1'b0;
        end
    end

    assign cell_key   = key_reg;
    assign cell_value = value_reg;
    assign match      = match_reg;

endmodule

### hw/rtl/ordered_multiset_bag.sv
// Bounded bag of key/value pairs held in a row of CAPACITY cells, oldest
// entry in cell 0. Every cell compares its key with the request key in the
// cycle the request is accepted and keeps the result in a match flag. An add
// writes its pair into the first free cell in that same cycle unless the bag
// is full, so the pair is taken while still on the input ports. Once the
// output register is free the sequencer acts on the flags: add, remove, find
// and a find-all with no match give one result; a find-all with N matches
// gives N, one per cycle unless stalled, as the lowest remaining match flag
// is picked and cleared. A remove shifts all later cells down by one as it
// gives its result. A new request is taken once the previous one has handed
// its last result to the output register, which holds it until out_ready.
module ordered_multiset_bag
#(
    parameter int CAPACITY = omb_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic signed [omb_pkg::KEY_W-1:0] key,
    input  logic [omb_pkg::VAL_W-1:0]       item_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic signed [omb_pkg::KEY_W-1:0] entry_key,
    output logic [omb_pkg::VAL_W-1:0]       entry_value,
    output logic                            last,
    output logic [1:0]                      status,
    output logic [omb_pkg::COUNT_OUT_W-1:0] entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                    state_reg, state_next;
    omb_pkg::func_t            op_reg, op_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [omb_pkg::KEY_W-1:0] entry_key_reg, entry_key_next;
    logic [omb_pkg::VAL_W-1:0] entry_value_reg, entry_value_next;
    logic                      last_reg, last_next;
    omb_pkg::status_t          status_reg, status_next;

    logic [omb_pkg::KEY_W-1:0] cell_key [CAPACITY];
    logic [omb_pkg::VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       match_vec;
    logic [CAPACITY-1:0]       pick;
    logic [CAPACITY-1:0]       at_or_after;
    logic [CAPACITY-1:0]       rest;
    logic                      any_match;
    logic [omb_pkg::KEY_W-1:0] sel_key;
    logic [omb_pkg::VAL_W-1:0] sel_value;
    logic                      accept;
    logic                      slot_free;
    logic                      act;
    logic                      is_full;
    logic                      do_write;
    logic                      do_shift;
    logic                      do_clear;
    omb_pkg::cell_ctrl_t       ctrl [CAPACITY];

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign act       = (state_reg == S_EXEC) && slot_free;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // Oldest match: lowest set flag; cells from it upward shift on remove
    assign pick        = match_vec & (~match_vec + CAPACITY'(1));
    assign at_or_after = ~(pick - CAPACITY'(1));
    assign rest        = match_vec & ~pick;
    assign any_match   = |match_vec;

    // Read out the picked cell
    always_comb
    begin
        sel_key   = '0;
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_key   = sel_key | ({omb_pkg::KEY_W{pick[i]}} & cell_key[i]);
            sel_value = sel_value | ({omb_pkg::VAL_W{pick[i]}} & cell_value[i]);
        end
    end

    // Add loads the pair from the ports at acceptance; count follows on act
    assign do_write = accept && (func == omb_pkg::FUNC_ADD) && !is_full;
    assign do_shift = act && (op_reg == omb_pkg::FUNC_REMOVE) && any_match;
    assign do_clear = act && (op_reg == omb_pkg::FUNC_FIND_ALL);

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [omb_pkg::KEY_W-1:0] nkey;
        logic [omb_pkg::VAL_W-1:0] nvalue;

        if (g == CAPACITY - 1)
        begin : g_end
            assign nkey   = '0;
            assign nvalue = '0;
        end
        else
        begin : g_mid
            assign nkey   = cell_key[g+1];
            assign nvalue = cell_value[g+1];
        end

        always_comb
        begin
            ctrl[g].capture  = accept;
            ctrl[g].occupied = (CNT_W'(g) < count_reg);
            ctrl[g].write    = do_write && (count_reg == CNT_W'(g));
            ctrl[g].shift    = do_shift && at_or_after[g];
            ctrl[g].clear    = do_clear && pick[g];
        end

        omb_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl[g]),
            .in_key     (key),
            .in_value   (item_value),
            .next_key   (nkey),
            .next_value (nvalue),
            .cell_key   (cell_key[g]),
            .cell_value (cell_value[g]),
            .match      (match_vec[g])
        );
    end

    // Sequencer and result register
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        entry_key_next   = entry_key_reg;
        entry_value_next = entry_value_reg;
        last_next        = last_reg;
        status_next      = status_reg;

        if (accept)
        begin
            op_next    = omb_pkg::func_t'(func);
            state_next = S_EXEC;
        end

        if (act)
        begin
            out_valid_next   = 1'b1;
            found_next       = 1'b0;
            entry_key_next   = '0;
            entry_value_next = '0;
            last_next        = 1'b1;
            status_next      = omb_pkg::STATUS_OK;
            state_next       = S_IDLE;

            unique case (op_reg)
                omb_pkg::FUNC_ADD:
                begin
                    if (is_full)
                    begin
                        status_next = omb_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                omb_pkg::FUNC_REMOVE, omb_pkg::FUNC_FIND:
                begin
                    if (!any_match)
                    begin
                        status_next = omb_pkg::STATUS_MISS;
                    end
                    else
                    begin
                        found_next       = 1'b1;
                        entry_key_next   = sel_key;
                        entry_value_next = sel_value;
                        if (op_reg == omb_pkg::FUNC_REMOVE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                omb_pkg::FUNC_FIND_ALL:
                begin
                    if (!any_match)
                    begin
                        status_next = omb_pkg::STATUS_MISS;
                    end
                    else
                    begin
                        found_next       = 1'b1;
                        entry_key_next   = sel_key;
                        entry_value_next = sel_value;
                        last_next        = (rest == '0);
                        if (rest != '0)
                        begin
                            state_next = S_EXEC;
                        end
                    end
                end
                default:
                begin
                    status_next = omb_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= omb_pkg::FUNC_ADD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        found_reg       <= found_next;
        entry_key_reg   <= entry_key_next;
        entry_value_reg <= entry_value_next;
        last_reg        <= last_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign entry_key   = entry_key_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign entry_count = omb_pkg::COUNT_OUT_W'(count_reg);

endmodule

### bench/tb_ordered_multiset_bag.sv
`timescale 1ns / 100ps

module tb_ordered_multiset_bag;

    localparam int          BAG_DEPTH   = omb_pkg::CAPACITY_DEF;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_ONES    = 32'hFFFF_FFFF;

    typedef enum int {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED
    } phase_kind_t;

    // One expected response of the bag
    typedef struct {
        logic              found;
        logic [31:0]       entry_key;
        logic [7:0]        entry_value;
        logic              last;
        omb_pkg::status_t  status;
        logic [4:0]        entry_count;
    } bag_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic signed [31:0]   key;
    logic [7:0]           item_value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 found;
    logic signed [31:0]   entry_key;
    logic [7:0]           entry_value;
    logic                 last;
    logic [1:0]           status;
    logic [4:0]           entry_count;

    // Shadow copy of the bag contents, oldest entry first
    logic [31:0]          bag_key [BAG_DEPTH];
    logic [7:0]           bag_val [BAG_DEPTH];
    int                   bag_count;

    bag_result_t          pending_results[$];
    int                   mismatch_count;
    int                   idle_streak;
    bit                   sender_calm;
    bit                   receiver_calm;

    ordered_multiset_bag #(
        .CAPACITY    (BAG_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key         (key),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .last        (last),
        .status      (status),
        .entry_count (entry_count)
    );

    always #2 clk = ~clk;

    // Gap length for one request or one result; zero during calm stretches
    function automatic int idle_cycles(bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic bag_result_t make_result(logic hit, logic [31:0] k, logic [7:0] v,
                                                logic fin, omb_pkg::status_t st);
        bag_result_t r;
        r.found       = hit;
        r.entry_key   = k;
        r.entry_value = v;
        r.last        = fin;
        r.status      = st;
        r.entry_count = bag_count[4:0];
        return r;
    endfunction

    // Apply one accepted request to the shadow bag and queue its responses
    function automatic void apply_bag_request(omb_pkg::func_t op, logic [31:0] k,
                                              logic [7:0] v);
        int first_hit;
        int last_hit;
        logic [31:0] hit_key;
        logic [7:0] hit_val;
        first_hit = -1;
        last_hit  = -1;
        for (int i = 0; i < bag_count; i++)
        begin
            if (bag_key[i] == k)
            begin
                if (first_hit < 0)
                    first_hit = i;
                last_hit = i;
            end
        end
        case (op)
            omb_pkg::FUNC_ADD:
            begin
                if (bag_count >= BAG_DEPTH)
                    pending_results.push_back(make_result(1'b0, '0, '0, 1'b1,
                                                          omb_pkg::STATUS_FULL));
                else
                begin
                    bag_key[bag_count] = k;
                    bag_val[bag_count] = v;
                    bag_count++;
                    pending_results.push_back(make_result(1'b0, '0, '0, 1'b1,
                                                          omb_pkg::STATUS_OK));
                end
            end
            omb_pkg::FUNC_FIND_ALL:
            begin
                if (last_hit < 0)
                    pending_results.push_back(make_result(1'b0, '0, '0, 1'b1,
                                                          omb_pkg::STATUS_MISS));
                for (int i = 0; i <= last_hit; i++)
                    if (bag_key[i] == k)
                        pending_results.push_back(make_result(1'b1, bag_key[i], bag_val[i],
                                                              i == last_hit,
                                                              omb_pkg::STATUS_OK));
            end
            default:
            begin
                if (first_hit < 0)
                    pending_results.push_back(make_result(1'b0, '0, '0, 1'b1,
                                                          omb_pkg::STATUS_MISS));
                else
                begin
                    hit_key = bag_key[first_hit];
                    hit_val = bag_val[first_hit];
                    // remove closes the gap, keeping insertion order
                    if (op == omb_pkg::FUNC_REMOVE)
                    begin
                        for (int i = first_hit; i + 1 < bag_count; i++)
                        begin
                            bag_key[i] = bag_key[i + 1];
                            bag_val[i] = bag_val[i + 1];
                        end
                        bag_count--;
                    end
                    pending_results.push_back(make_result(1'b1, hit_key, hit_val, 1'b1,
                                                          omb_pkg::STATUS_OK));
                end
            end
        endcase
    endfunction

    // Compare the response on the output port with the oldest expectation
    function automatic void check_bag_result();
        bag_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: found=%0d entry_key=%h status=%0d",
                   found, entry_key, status);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        if (found !== want.found)
        begin
            $error("found: expected %0d, actual %0d", want.found, found);
            mismatch_count++;
        end
        if (entry_key !== want.entry_key)
        begin
            $error("entry_key: expected %h, actual %h", want.entry_key, entry_key);
            mismatch_count++;
        end
        if (entry_value !== want.entry_value)
        begin
            $error("entry_value: expected %h, actual %h", want.entry_value, entry_value);
            mismatch_count++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, last);
            mismatch_count++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
        end
        if (entry_count !== want.entry_count)
        begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            mismatch_count++;
        end
    endfunction

    // Both handshakes observed at the edge; results first, they belong to older requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_bag_result();
            if (in_valid && in_ready)
                apply_bag_request(omb_pkg::func_t'(func), key, item_value);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_streak <= 0;
            else if (idle_streak >= STALL_LIMIT)
            begin
                $display("** ordered_multiset_bag: FAILED **");
                $finish;
            end
            else
                idle_streak <= idle_streak + 1;
        end
    end

    // Result side: random stall before each result
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_cycles(receiver_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Present one request and hold it until taken
    task automatic send_request(omb_pkg::func_t op, logic [31:0] k, logic [7:0] v);
        int gap;
        gap = idle_cycles(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        key        <= k;
        item_value <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending until every queued response has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Lookups and removal on an empty bag all miss
    task automatic test_empty_bag();
        send_request(omb_pkg::FUNC_REMOVE, KEY_MIN, 8'hFF);
        send_request(omb_pkg::FUNC_FIND, 32'h0, 8'h00);
        send_request(omb_pkg::FUNC_FIND_ALL, KEY_MAX, 8'h5A);
    endtask

    // Fill to capacity with duplicates, overflow, then search and remove
    task automatic test_fill_and_overflow();
        logic [31:0] k;
        logic [7:0] v;
        receiver_calm = 1'b1;
        for (int i = 0; i < BAG_DEPTH; i++)
        begin
            if (i % 3 == 0)
                k = KEY_ONES;
            else if (i == 1)
                k = KEY_MIN;
            else if (i == 2)
                k = KEY_MAX;
            else if (i == 4)
                k = 32'h0;
            else
                k = $urandom;
            v = (i == 0) ? 8'h00 : (i == BAG_DEPTH - 1) ? 8'hFF : 8'($urandom_range(0, 255));
            send_request(omb_pkg::FUNC_ADD, k, v);
        end
        receiver_calm = 1'b0;
        send_request(omb_pkg::FUNC_ADD, KEY_MAX, 8'hAA);
        send_request(omb_pkg::FUNC_FIND_ALL, KEY_ONES, 8'h00);
        send_request(omb_pkg::FUNC_FIND, KEY_MAX, 8'h00);
        send_request(omb_pkg::FUNC_REMOVE, KEY_ONES, 8'h00);
        send_request(omb_pkg::FUNC_REMOVE, KEY_MIN, 8'h00);
        send_request(omb_pkg::FUNC_FIND_ALL, KEY_ONES, 8'h00);
    endtask

    // Empty the bag, refill it with one key and list all of it
    task automatic test_deep_find_all();
        logic [31:0] snapshot [BAG_DEPTH];
        int held;
        logic [31:0] k;
        drain_results();
        held = bag_count;
        for (int i = 0; i < held; i++)
            snapshot[i] = bag_key[i];
        // removing in stored order always hits the oldest entry
        for (int i = 0; i < held; i++)
            send_request(omb_pkg::FUNC_REMOVE, snapshot[i], 8'($urandom_range(0, 255)));
        k = $urandom;
        for (int i = 0; i < BAG_DEPTH; i++)
            send_request(omb_pkg::FUNC_ADD, k, 8'($urandom_range(0, 255)));
        send_request(omb_pkg::FUNC_FIND_ALL, k, 8'h00);
        send_request(omb_pkg::FUNC_ADD, ~k, 8'($urandom_range(0, 255)));
        send_request(omb_pkg::FUNC_FIND_ALL, ~k, 8'h00);
        send_request(omb_pkg::FUNC_REMOVE, k, 8'h00);
        send_request(omb_pkg::FUNC_FIND_ALL, k, 8'h00);
    endtask

    // Random traffic in phases that grow, shrink or churn the bag
    task automatic test_random_mix(int n_items);
        logic [31:0] key_pool [4];
        phase_kind_t phase;
        omb_pkg::func_t op;
        logic [31:0] k;
        int pick;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 30 == 0)
            begin
                if (n != 0 && $urandom_range(0, 2) == 0)
                    drain_results();
                phase         = phase_kind_t'($urandom_range(0, 2));
                sender_calm   = ($urandom_range(0, 3) == 0);
                receiver_calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: key_pool[0] = KEY_MIN;
                    1: key_pool[0] = KEY_MAX;
                    default: key_pool[0] = KEY_ONES;
                endcase
                key_pool[1] = $urandom;
                key_pool[2] = $urandom;
                key_pool[3] = $urandom_range(0, 3);
            end
            pick = $urandom_range(0, 99);
            case (phase)
                PHASE_GROW:
                    op = (pick < 55) ? omb_pkg::FUNC_ADD : (pick < 65) ? omb_pkg::FUNC_REMOVE :
                         (pick < 80) ? omb_pkg::FUNC_FIND : omb_pkg::FUNC_FIND_ALL;
                PHASE_SHRINK:
                    op = (pick < 20) ? omb_pkg::FUNC_ADD : (pick < 65) ? omb_pkg::FUNC_REMOVE :
                         (pick < 80) ? omb_pkg::FUNC_FIND : omb_pkg::FUNC_FIND_ALL;
                default:
                    op = (pick < 35) ? omb_pkg::FUNC_ADD : (pick < 60) ? omb_pkg::FUNC_REMOVE :
                         (pick < 80) ? omb_pkg::FUNC_FIND : omb_pkg::FUNC_FIND_ALL;
            endcase
            if ($urandom_range(0, 3) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, 3)];
            send_request(op, k, 8'($urandom_range(0, 255)));
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        func           = omb_pkg::FUNC_ADD;
        key            = '0;
        item_value     = '0;
        bag_count      = 0;
        mismatch_count = 0;
        idle_streak    = 0;
        sender_calm    = 1'b0;
        receiver_calm  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_bag();
        test_fill_and_overflow();
        test_random_mix(80);
        test_deep_find_all();
        test_random_mix(80);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("** ordered_multiset_bag: PASSED **");
        else
            $display("** ordered_multiset_bag: FAILED **");
        $finish;
    end

endmodule
